// ----- hw/rtl/gfau_pkg.sv -----
// ----------------------------------------------------------------------------
// gfau_pkg: shared types, constants and field math for the GF(2^8) unit
// Holds the command codes, the word that travels down the cell chain and the
// GF(2^8) multiply reduced by x^8 + x^4 + x^3 + x^2 + 1.
// ----------------------------------------------------------------------------
package gfau_pkg;

    localparam int unsigned GF_BITS     = 8;
    localparam logic [8:0]  GF_POLY     = 9'h11D;
    localparam logic [7:0]  GF_HIGHBIT  = 8'h80;
    localparam logic [7:0]  GF_ONE      = 8'h01;
    localparam logic [7:0]  GF_ZERO     = 8'h00;

    // One cell per exponent bit.
    localparam int unsigned GFAU_STAGES = GF_BITS;

    typedef enum logic [1:0] {
        CMD_XOR = 2'd0,
        CMD_MUL = 2'd1,
        CMD_POW = 2'd2
    } gfau_cmd_t;

    // Running product, running square and the exponent bits still to consume.
    typedef struct packed {
        logic [GF_BITS-1:0] acc;
        logic [GF_BITS-1:0] sq;
        logic [GF_BITS-1:0] expo;
    } gfau_word_t;

    function automatic logic [GF_BITS-1:0] gf_mul(
        input logic [GF_BITS-1:0] x_in,
        input logic [GF_BITS-1:0] y_in
    );
        logic [GF_BITS-1:0] acc;
        logic [GF_BITS-1:0] x;
        acc = GF_ZERO;
        x   = x_in;
        for (int i = 0; i < GF_BITS; i++) begin
            if (y_in[i]) begin
                acc = acc ^ x;
            end
            if ((x & GF_HIGHBIT) != GF_ZERO) begin
                x = {x[GF_BITS-2:0], 1'b0} ^ GF_POLY[GF_BITS-1:0];
            end else begin
                x = {x[GF_BITS-2:0], 1'b0};
            end
        end
        return acc;
    endfunction

endpackage

// ----- hw/rtl/gf256_arith_unit.sv -----
// ----------------------------------------------------------------------------
// gf256_arith_unit: GF(2^8) add, multiply and power, polynomial 0x11D
// Pipelined chain of eight identical square-and-multiply cells.
// ----------------------------------------------------------------------------
// Usage: each input word carries a command and two bytes and yields exactly
// one result byte. Command add/subtract returns operand_a xor operand_b,
// multiply returns the field product reduced by x^8+x^4+x^3+x^2+1, power
// returns operand_a raised to operand_b (0..255), with any base to the zeroth
// power giving 1; the unused command code returns 0. Every word walks a chain
// of eight registered cells, one per exponent bit, and the unit takes one new
// word every cycle unless the chain is stalled. All commands share the chain:
// multiply enters as a one-bit exponent and xor as a finished value with an
// empty exponent. The whole chain advances together; it stalls only while the
// last cell holds a result that m_ready has not taken, so s_ready mirrors that
// condition.
// ----------------------------------------------------------------------------
module gf256_arith_unit
    import gfau_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [7:0] s_operand_a,
    input  logic [7:0] s_operand_b,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_result
);

    // One cell per exponent bit; the depth is fixed by the field width.
    localparam int unsigned STAGES = GFAU_STAGES;

    logic       stage_valid [0:STAGES];
    gfau_word_t stage_word  [0:STAGES];
    gfau_word_t entry_word;
    logic       advance;

    // Advance the chain whenever the output slot is empty or being drained.
    assign advance = !stage_valid[STAGES] || m_ready;
    assign s_ready = advance;

    // Map each command onto the uniform cell step.
    always_comb begin
        unique case (s_cmd)
            CMD_XOR: begin
                entry_word.acc  = s_operand_a ^ s_operand_b;
                entry_word.sq   = GF_ZERO;
                entry_word.expo = GF_ZERO;
            end
            CMD_MUL: begin
                // One set exponent bit: the first cell forms a * b.
                entry_word.acc  = s_operand_a;
                entry_word.sq   = s_operand_b;
                entry_word.expo = GF_ONE;
            end
            CMD_POW: begin
                entry_word.acc  = GF_ONE;
                entry_word.sq   = s_operand_a;
                entry_word.expo = s_operand_b;
            end
            default: begin
                // Unused code: drop to zero and let it ride through untouched.
                entry_word.acc  = GF_ZERO;
                entry_word.sq   = GF_ZERO;
                entry_word.expo = GF_ZERO;
            end
        endcase
    end

    assign stage_valid[0] = s_valid;
    assign stage_word[0]  = entry_word;

    for (genvar i = 0; i < STAGES; i++) begin : g_cell
        gfau_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (stage_valid[i]),
            .in_word   (stage_word[i]),
            .out_valid (stage_valid[i+1]),
            .out_word  (stage_word[i+1])
        );
    end

    // The last cell doubles as the output register.
    assign m_valid  = stage_valid[STAGES];
    assign m_result = stage_word[STAGES].acc;

endmodule

// ----- hw/rtl/gfau_cell.sv -----
// ----------------------------------------------------------------------------
// gfau_cell: one square-and-multiply step
// Consumes the low exponent bit: multiply the running product by the running
// square when the bit is set, square the running square, shift the exponent.
// ----------------------------------------------------------------------------
module gfau_cell
    import gfau_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic       in_valid,
    input  gfau_word_t in_word,
    output logic       out_valid,
    output gfau_word_t out_word
);

    logic       valid_reg;
    gfau_word_t word_reg;
    gfau_word_t word_next;

    always_comb begin
        word_next.acc  = in_word.expo[0] ? gf_mul(in_word.acc, in_word.sq) : in_word.acc;
        word_next.sq   = gf_mul(in_word.sq, in_word.sq);
        word_next.expo = {1'b0, in_word.expo[GF_BITS-1:1]};
    end

    // Hold the valid flag clean across reset; payload needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule
